[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Result types, result kinds and the byte thresholds of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    // Lead byte ranges.
    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] LEAD_LIMIT = 8'hF5;

    // Second byte limits after E0, F0 and F4.
    localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
    localparam logic [7:0] F0_SECOND_MIN = 8'h90;

    // Surrogate pair construction.
    localparam logic [15:0] HIGH_SURR_OFFSET = 16'hD7C0;
    localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;

    typedef enum logic [1:0] {
        KIND_UNIT  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] code_unit;
        logic        written;
        logic [15:0] unit_count;
        logic        last;
    } result_t;

    // Results produced by one accepted byte: zero, one or two.
    typedef struct packed {
        logic [1:0] n_res;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

endpackage

[sv/utf8_to_utf16_stream.sv]
// Each accepted byte's results are written into the result queue, which offers them on the m_ side.
// Throughput: one byte per cycle while the queue has room; a surrogate pair leaves as two beats.
// The input stalls only when the result queue cannot hold two more beats.
// Reset (aresetn low, synchronous) clears the decode state, the unit count and the queue,
// and sets the capacity register to 256 units. No clearing pass is needed.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream transcoder
// Decodes a NUL-terminated UTF-8 byte stream into UTF-16 code units with
// validation, capacity marking and a done or error beat that ends each string.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Capacity register write port.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // capacity_units

    // Input byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] in_byte

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // [15:0] code_unit, [16] written,
                                       // [32:17] unit_count, [39:33] zero
    output logic [1:0]  m_tuser,       // [1:0] kind
    output logic        m_tlast        // last result of its input byte
);

    logic                 accept;
    logic                 room;
    logic [15:0]          capacity_reg;
    u8u16_pkg::dec_out_t  dec_out;
    u8u16_pkg::result_t   m_res;

    // The capacity register is to be written only while the stream is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= u8u16_pkg::CAPACITY_RESET;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    // A byte is taken whenever the queue has space for the two beats a
    // four-byte sequence can produce; the queue drains independently.
    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    // Decode state lives in the decoder; results go straight to the queue.
    u8u16_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_byte  (s_tdata),
        .capacity (capacity_reg),
        .dec_out  (dec_out)
    );

    u8u16_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .dec_out  (dec_out),
        .room     (room),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    // Pack the result beat.
    assign m_tdata = {7'd0, m_res.unit_count, m_res.written, m_res.code_unit};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule

[sv/u8u16_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder
// Holds the per-string decode state and turns each byte into its results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u16_decode #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic [15:0]          capacity,
    output u8u16_pkg::dec_out_t  dec_out
);

    localparam int CMPW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        LC_NONE = 2'd0,
        LC_E0   = 2'd1,
        LC_F0   = 2'd2,
        LC_F4   = 2'd3
    } lead_check_t;

    logic [20:0]            code_accum_reg, code_accum_next;
    logic [1:0]             bytes_left_reg, bytes_left_next;
    lead_check_t            lead_check_reg, lead_check_next;
    logic                   second_pending_reg, second_pending_next;
    logic [COUNT_WIDTH-1:0] units_reg, units_next;

    logic                   do_emit;
    logic                   do_error;
    logic                   do_done;
    logic [20:0]            emit_cp;
    logic [20:0]            accum_shift;
    logic [1:0]             left_dec;
    logic                   is_pair;
    logic [COUNT_WIDTH-1:0] count1;
    logic [COUNT_WIDTH-1:0] count2;
    logic [CMPW-1:0]        count1_ext;
    logic [CMPW-1:0]        count2_ext;
    logic [CMPW-1:0]        units_ext;
    logic [CMPW-1:0]        need_ext;
    logic                   fits;
    logic                   bad_second;

    assign accum_shift = {code_accum_reg[14:0], in_byte[5:0]};
    assign left_dec    = bytes_left_reg - 2'd1;

    assign bad_second = second_pending_reg &&
        ((lead_check_reg == LC_E0 && in_byte < u8u16_pkg::E0_SECOND_MIN) ||
         (lead_check_reg == LC_F0 && in_byte < u8u16_pkg::F0_SECOND_MIN) ||
         (lead_check_reg == LC_F4 && in_byte >= u8u16_pkg::F0_SECOND_MIN));

    // Byte classification and next decode state.
    always_comb begin
        code_accum_next     = code_accum_reg;
        bytes_left_next     = bytes_left_reg;
        lead_check_next     = lead_check_reg;
        second_pending_next = second_pending_reg;
        do_emit  = 1'b0;
        do_error = 1'b0;
        do_done  = 1'b0;
        emit_cp  = '0;
        if (bytes_left_reg == 2'd0) begin
            if (in_byte == 8'd0) begin
                do_done = 1'b1;
            end else if (!in_byte[7]) begin
                do_emit = 1'b1;
                emit_cp = {13'd0, in_byte};
            end else if (in_byte < u8u16_pkg::LEAD_MIN ||
                         in_byte >= u8u16_pkg::LEAD_LIMIT) begin
                do_error = 1'b1;
            end else begin
                second_pending_next = 1'b1;
                if (in_byte < u8u16_pkg::LEAD3_MIN) begin
                    code_accum_next = {16'd0, in_byte[4:0]};
                    bytes_left_next = 2'd1;
                    lead_check_next = LC_NONE;
                end else if (in_byte < u8u16_pkg::LEAD4_MIN) begin
                    code_accum_next = {17'd0, in_byte[3:0]};
                    bytes_left_next = 2'd2;
                    lead_check_next = (in_byte == u8u16_pkg::LEAD3_MIN) ? LC_E0 : LC_NONE;
                end else begin
                    code_accum_next = {18'd0, in_byte[2:0]};
                    bytes_left_next = 2'd3;
                    if (in_byte == u8u16_pkg::LEAD4_MIN) begin
                        lead_check_next = LC_F0;
                    end else if (in_byte == u8u16_pkg::LEAD_F4) begin
                        lead_check_next = LC_F4;
                    end else begin
                        lead_check_next = LC_NONE;
                    end
                end
            end
        end else begin
            if (in_byte[7:6] != 2'b10 || bad_second) begin
                do_error = 1'b1;
            end else begin
                second_pending_next = 1'b0;
                lead_check_next     = LC_NONE;
                bytes_left_next     = left_dec;
                if (left_dec == 2'd0) begin
                    code_accum_next = '0;
                    do_emit = 1'b1;
                    emit_cp = accum_shift;
                end else begin
                    code_accum_next = accum_shift;
                end
            end
        end
        if (do_error || do_done) begin
            code_accum_next     = '0;
            bytes_left_next     = 2'd0;
            lead_check_next     = LC_NONE;
            second_pending_next = 1'b0;
        end
    end

    // Unit counting with saturation and the capacity check.
    assign is_pair    = (emit_cp[20:16] != 5'd0);
    assign count1     = (units_reg == COUNT_MAX) ? COUNT_MAX : units_reg + 1'b1;
    assign count2     = (count1 == COUNT_MAX) ? COUNT_MAX : count1 + 1'b1;
    assign count1_ext = CMPW'(count1);
    assign count2_ext = CMPW'(count2);
    assign units_ext  = CMPW'(units_reg);
    assign need_ext   = units_ext + (is_pair ? CMPW'(2) : CMPW'(1));
    assign fits       = (need_ext <= CMPW'(capacity));

    always_comb begin
        units_next      = units_reg;
        dec_out         = '0;
        dec_out.res0.kind = u8u16_pkg::KIND_UNIT;
        dec_out.res1.kind = u8u16_pkg::KIND_UNIT;
        if (do_done) begin
            units_next = '0;
            dec_out.n_res           = 2'd1;
            dec_out.res0.kind       = u8u16_pkg::KIND_DONE;
            dec_out.res0.unit_count = units_ext[15:0];
            dec_out.res0.last       = 1'b1;
        end else if (do_error) begin
            units_next = '0;
            dec_out.n_res     = 2'd1;
            dec_out.res0.kind = u8u16_pkg::KIND_ERROR;
            dec_out.res0.last = 1'b1;
        end else if (do_emit && !is_pair) begin
            units_next = count1;
            dec_out.n_res           = 2'd1;
            dec_out.res0.code_unit  = emit_cp[15:0];
            dec_out.res0.written    = fits;
            dec_out.res0.unit_count = count1_ext[15:0];
            dec_out.res0.last       = 1'b1;
        end else if (do_emit) begin
            units_next = count2;
            dec_out.n_res           = 2'd2;
            dec_out.res0.code_unit  = {5'd0, emit_cp[20:10]} + u8u16_pkg::HIGH_SURR_OFFSET;
            dec_out.res0.written    = fits;
            dec_out.res0.unit_count = count1_ext[15:0];
            dec_out.res1.code_unit  = {6'd0, emit_cp[9:0]} + u8u16_pkg::LOW_SURR_BASE;
            dec_out.res1.written    = fits;
            dec_out.res1.unit_count = count2_ext[15:0];
            dec_out.res1.last       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_accum_reg     <= '0;
            bytes_left_reg     <= 2'd0;
            lead_check_reg     <= LC_NONE;
            second_pending_reg <= 1'b0;
            units_reg          <= '0;
        end else if (accept) begin
            code_accum_reg     <= code_accum_next;
            bytes_left_reg     <= bytes_left_next;
            lead_check_reg     <= lead_check_next;
            second_pending_reg <= second_pending_next;
            units_reg          <= units_next;
        end
    end

    `ASSERT_IMPL(a_pending_in_seq, aclk, aresetn, bytes_left_reg == 2'd0, !second_pending_reg)
    `ASSERT_NEXT(a_clear_after_end, aclk, aresetn,
                 accept && (do_done || do_error),
                 bytes_left_reg == 2'd0 && units_reg == '0)
    `ASSERT_IMPL(a_pair_last, aclk, aresetn, dec_out.n_res == 2'd2,
                 dec_out.res1.last && !dec_out.res0.last)

endmodule

[sv/u8u16_outq.sv]
// ----------------------------------------------------------------------------
// Result queue
// Four-entry register queue that takes up to two results a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u16_outq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  u8u16_pkg::dec_out_t  dec_out,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u8u16_pkg::result_t   m_res
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    u8u16_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic [1:0]         push_n;
    logic               pop;
    logic [AW-1:0]      wr_ptr_1;

    assign push_n   = push ? dec_out.n_res : 2'd0;
    assign pop      = m_valid && m_ready;
    assign wr_ptr_1 = wr_ptr_reg + 1'b1;
    assign m_valid  = (count_reg != '0);
    assign m_res    = mem_reg[rd_ptr_reg];
    // Room for the largest burst a byte can cause.
    assign room     = (count_reg <= (AW+1)'(DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= dec_out.res0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_1] <= dec_out.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + AW'(pop);
            count_reg  <= count_reg + (AW+1)'(push_n) - (AW+1)'(pop);
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, count_reg <= (AW+1)'(DEPTH))
    `ASSERT_ALWAYS(a_push_range, aclk, aresetn, push_n != 2'd3)
    `ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && push_n == 2'd0,
                 count_reg == $past(count_reg) - 1'b1)

endmodule

[tb/sv/tb_utf8_to_utf16_stream.sv]
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 to UTF-16 stream transcoder
// Feeds NUL-terminated UTF-8 strings through the byte stream. Directed cases
// cover the encoding limits, every rejection rule and capacity marking.
// Random strings follow, with noise and broken sequences mixed in.
// A built-in decoder predicts every result beat, and a monitor compares each
// beat on the result stream with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_stream;

    // Cycles without any accepted beat on either stream before the run is abandoned.
    localparam int unsigned STALL_LIMIT  = 2000;
    // Minimum number of random bytes to send after the directed tests.
    localparam int unsigned RANDOM_BYTES = 1075;
    // The unit count stops at this value.
    localparam int unsigned COUNT_MAX    = (1 << u8u16_pkg::COUNT_WIDTH_DEFAULT) - 1;

    // Restriction that applies to the second byte of a multi-byte sequence.
    typedef enum logic [1:0] {
        SECOND_ANY,       // any continuation byte
        SECOND_MIN_A0,    // after E0: at least A0, otherwise the form is overlong
        SECOND_MIN_90,    // after F0: at least 90, otherwise the form is overlong
        SECOND_BELOW_90   // after F4: below 90, otherwise above U+10FFFF
    } second_rule_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;        // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;        // [15:0] code_unit, [16] written, [32:17] unit_count
    logic [1:0]  m_tuser;        // [1:0] kind
    logic        m_tlast;

    // Decoder state of the prediction. It mirrors what the block holds.
    logic [20:0]  cp_bits;
    logic [1:0]   cont_left;
    second_rule_t second_rule;
    logic         second_next;
    int unsigned  unit_total;
    logic [15:0]  capacity;

    // Result beats that are predicted but have not yet been seen on the result stream.
    u8u16_pkg::result_t utf16_queue[$];

    // When set, both sides run back to back with no idle cycles.
    logic               no_idle;
    int unsigned        bytes_sent;
    int unsigned        mismatches;
    u8u16_pkg::result_t want;

    utf8_to_utf16_stream u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic u8u16_pkg::result_t mk_result(input u8u16_pkg::kind_t k,
                                                     input logic [15:0] unit,
                                                     input logic wr,
                                                     input logic [15:0] count,
                                                     input logic lst);
        u8u16_pkg::result_t r;
        r.kind       = k;
        r.code_unit  = unit;
        r.written    = wr;
        r.unit_count = count;
        r.last       = lst;
        return r;
    endfunction

    // A done or an error puts the decoder back into its reset state.
    // The capacity register is not part of that state.
    function automatic void clear_decoder();
        cp_bits     = '0;
        cont_left   = '0;
        second_rule = SECOND_ANY;
        second_next = 1'b0;
        unit_total  = 0;
    endfunction

    function automatic void bump_count();
        if (unit_total < COUNT_MAX)
            unit_total = unit_total + 1;
    endfunction

    function automatic void flag_error();
        clear_decoder();
        utf16_queue.push_back(mk_result(u8u16_pkg::KIND_ERROR, 16'h0000, 1'b0,
                                        16'h0000, 1'b1));
    endfunction

    // A finished code point leaves as one unit, or as a surrogate pair with the
    // high unit first. Both units of a pair share one written flag, which is
    // decided on the count before the pair.
    function automatic void emit_utf16(input logic [20:0] cp);
        int unsigned n;
        logic        fits;
        logic [15:0] hi;
        logic [15:0] lo;
        n    = (cp < 21'h10000) ? 1 : 2;
        fits = (unit_total + n) <= 32'(capacity);
        if (n == 1) begin
            bump_count();
            utf16_queue.push_back(mk_result(u8u16_pkg::KIND_UNIT, cp[15:0], fits,
                                            unit_total[15:0], 1'b1));
        end else begin
            hi = {5'd0, cp[20:10]} + u8u16_pkg::HIGH_SURR_OFFSET;
            lo = {6'd0, cp[9:0]} + u8u16_pkg::LOW_SURR_BASE;
            bump_count();
            utf16_queue.push_back(mk_result(u8u16_pkg::KIND_UNIT, hi, fits,
                                            unit_total[15:0], 1'b0));
            bump_count();
            utf16_queue.push_back(mk_result(u8u16_pkg::KIND_UNIT, lo, fits,
                                            unit_total[15:0], 1'b1));
        end
    endfunction

    // Advances the decoder by one accepted byte and queues the beats it causes.
    function automatic void transcode_byte(input logic [7:0] b);
        if (cont_left == 2'd0) begin
            if (b == 8'h00) begin
                utf16_queue.push_back(mk_result(u8u16_pkg::KIND_DONE, 16'h0000, 1'b0,
                                                unit_total[15:0], 1'b1));
                clear_decoder();
            end else if (b < 8'h80) begin
                emit_utf16({13'd0, b});
            end else if (b < u8u16_pkg::LEAD_MIN || b >= u8u16_pkg::LEAD_LIMIT) begin
                flag_error();
            end else begin
                second_next = 1'b1;
                if (b < u8u16_pkg::LEAD3_MIN) begin
                    cp_bits     = {16'd0, b[4:0]};
                    cont_left   = 2'd1;
                    second_rule = SECOND_ANY;
                end else if (b < u8u16_pkg::LEAD4_MIN) begin
                    cp_bits     = {17'd0, b[3:0]};
                    cont_left   = 2'd2;
                    second_rule = (b == u8u16_pkg::LEAD3_MIN) ? SECOND_MIN_A0 : SECOND_ANY;
                end else begin
                    cp_bits   = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                    if (b == u8u16_pkg::LEAD4_MIN)
                        second_rule = SECOND_MIN_90;
                    else if (b == u8u16_pkg::LEAD_F4)
                        second_rule = SECOND_BELOW_90;
                    else
                        second_rule = SECOND_ANY;
                end
            end
        end else if (b[7:6] != 2'b10) begin
            // Anything but a continuation byte inside a sequence, a NUL included.
            flag_error();
        end else if (second_next &&
                     ((second_rule == SECOND_MIN_A0   && b <  u8u16_pkg::E0_SECOND_MIN) ||
                      (second_rule == SECOND_MIN_90   && b <  u8u16_pkg::F0_SECOND_MIN) ||
                      (second_rule == SECOND_BELOW_90 && b >= u8u16_pkg::F0_SECOND_MIN)))
        begin
            flag_error();
        end else begin
            second_next = 1'b0;
            second_rule = SECOND_ANY;
            cp_bits     = {cp_bits[14:0], b[5:0]};
            cont_left   = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                emit_utf16(cp_bits);
                cp_bits = '0;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------------

    // Sends one byte. The byte waits a random number of cycles first, unless
    // the back-to-back mode is on. s_tvalid is only lowered when a gap is
    // taken, so a steady stream keeps it high across consecutive beats.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        transcode_byte(b);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            send_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            send_byte(8'hC0 | cp[10:6]);
            send_byte(8'h80 | cp[5:0]);
        end else if (cp < 21'h10000) begin
            send_byte(8'hE0 | cp[15:12]);
            send_byte(8'h80 | cp[11:6]);
            send_byte(8'h80 | cp[5:0]);
        end else begin
            send_byte(8'hF0 | cp[20:18]);
            send_byte(8'h80 | cp[17:12]);
            send_byte(8'h80 | cp[11:6]);
            send_byte(8'h80 | cp[5:0]);
        end
    endtask

    task automatic send_bytes(input logic [7:0] seq[]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Holds the byte stream off until every predicted beat has arrived. A lead
    // byte causes no beat, so the task waits on past the last beat before the
    // block counts as idle.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (utf16_queue.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        capacity   = value;
    endtask

    // The result side takes one beat at a time after a random stall.
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Result checking: each accepted beat is matched with the oldest prediction.
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (utf16_queue.size() == 0) begin
                $error("result beat with nothing predicted: kind %0d unit %h count %0d",
                       m_tuser, m_tdata[15:0], m_tdata[32:17]);
                mismatches = mismatches + 1;
            end else begin
                want = utf16_queue.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[15:0] !== want.code_unit) begin
                    $error("code_unit: expected %h, got %h", want.code_unit, m_tdata[15:0]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[16] !== want.written) begin
                    $error("written: expected %0d, got %0d", want.written, m_tdata[16]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[32:17] !== want.unit_count) begin
                    $error("unit_count: expected %0d, got %0d",
                           want.unit_count, m_tdata[32:17]);
                    mismatches = mismatches + 1;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // The run is abandoned when no beat moves on either stream for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The empty string, then the first and last code point of each encoding
    // length, a surrogate code point that passes through, and the top of the
    // code space as a surrogate pair.
    task automatic test_encoding_limits();
        send_bytes('{8'h00,
                     8'h01, 8'h7F,
                     8'hC2, 8'h80, 8'hDF, 8'hBF,
                     8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                     8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                     8'h00});
    endtask

    // Each rejection rule once. A count built up before an error must be
    // gone after it.
    task automatic test_rejections();
        send_bytes('{8'h41, 8'h80,          // stray continuation as a lead
                     8'h42, 8'h00,          // the count restarts after the error
                     8'hC1, 8'hF5, 8'hFF,   // lead bytes that can never start a sequence
                     8'hE0, 8'h9F,          // overlong three-byte form
                     8'hF0, 8'h8F,          // overlong four-byte form
                     8'hF4, 8'h90,          // beyond U+10FFFF
                     8'hC2, 8'h41,          // plain byte where a continuation belongs
                     8'hC2, 8'hC2,          // a new lead inside a sequence
                     8'hE1, 8'h80, 8'h00,   // NUL inside a sequence
                     8'h00});
    endtask

    // Capacity at zero, at a small value where a pair straddles the limit or
    // fits exactly, and at its maximum.
    task automatic test_capacity_marking();
        write_capacity(16'h0000);
        send_bytes('{8'h41, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h00});
        write_capacity(16'd3);
        send_bytes('{8'h41, 8'h42, 8'hF0, 8'h9F, 8'hBF, 8'hBF, 8'h43, 8'h00});
        send_bytes('{8'h41, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h44, 8'h00});
        write_capacity(16'hFFFF);
        send_bytes('{8'hF3, 8'hBF, 8'hBF, 8'hBF, 8'h7E, 8'h00});
        write_capacity(u8u16_pkg::CAPACITY_RESET);
    endtask

    function automatic logic [20:0] random_code_point();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(1, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2: begin
                if ($urandom_range(0, 7) == 0)
                    cp = 21'($urandom_range('hD800, 'hDFFF));
                else
                    cp = 21'($urandom_range('h800, 'hFFFF));
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // Mostly well-formed strings with random content. Some strings carry a
    // random byte or a sequence cut short before their NUL. The capacity moves
    // between phases, mostly around the lengths of the strings, and stretches
    // of back-to-back traffic alternate with random idling.
    task automatic test_random_strings();
        int unsigned first_byte;
        int unsigned strings;
        int unsigned chars;
        int unsigned twist;
        first_byte = bytes_sent;
        strings    = 0;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            if (strings % 6 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (strings % 9 == 8) begin
                if ($urandom_range(0, 3) == 0)
                    write_capacity(16'($urandom_range(0, 65535)));
                else
                    write_capacity(16'($urandom_range(0, 24)));
            end else if (strings % 13 == 5) begin
                drain_results();
            end
            chars = $urandom_range(0, 10);
            repeat (chars)
                send_code_point(random_code_point());
            twist = $urandom_range(0, 9);
            if (twist == 0) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (twist == 1) begin
                send_byte(8'($urandom_range(u8u16_pkg::LEAD_MIN, u8u16_pkg::LEAD_F4)));
                send_byte(8'($urandom_range(0, 255)));
            end
            send_byte(8'h00);
            strings = strings + 1;
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        cfg_we     = 1'b0;
        cfg_wdata  = 16'h0000;
        aresetn    = 1'b0;
        no_idle    = 1'b0;
        bytes_sent = 0;
        mismatches = 0;
        clear_decoder();
        capacity   = u8u16_pkg::CAPACITY_RESET;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_encoding_limits();
        test_rejections();
        test_capacity_marking();
        test_random_strings();

        // Every beat must be back before the verdict; a further wait after the drain
        // catches a stray beat after the last one.
        drain_results();
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && utf16_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[utf8_to_utf16_stream.f]
+incdir+sv
sv/u8u16_pkg.sv
sv/u8u16_decode.sv
sv/u8u16_outq.sv
sv/utf8_to_utf16_stream.sv
tb/sv/tb_utf8_to_utf16_stream.sv
